// ----- rtl/core/tick_stamp_wakeup_timer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef TICK_STAMP_WAKEUP_TIMER_TOP_ASSERT_SVH
`define TICK_STAMP_WAKEUP_TIMER_TOP_ASSERT_SVH

// same-cycle implication
`define TSWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSWT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tswt_pkg.sv -----
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer package
// Operation codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tswt_pkg;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 3;
  localparam int STAMP_W = 64;
  localparam int LEAP_W  = 32;
  localparam int MASK_W  = 8;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_AFTER  = 2'd1;
  localparam logic [OP_W-1:0] OP_BEFORE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic capture;
    logic calc;
    logic apply;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
  } stat_t;

endpackage

// ----- rtl/core/tswt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer controller
// Sequences capture, update, slot apply and result load for one item.
// ----------------------------------------------------------------------------
`include "tick_stamp_wakeup_timer_top_assert.svh"

module tswt_ctrl import tswt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state, state_next;
  logic       out_valid_next;

  assign in_ready     = (state == S_IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.calc     = (state == S_CALC) && !stat.skip;
  assign cmd.apply    = (state == S_APPLY);
  assign cmd.load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CALC;
      S_CALC:  state_next = stat.skip ? S_DONE : S_APPLY;
      S_APPLY: state_next = S_DONE;
      S_DONE:  if (cmd.load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `TSWT_ASSERT_NXT(a_accept_calc, in_valid && in_ready, state == S_CALC, "accept did not start item")
  `TSWT_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid || out_ready, "result overwritten")
  `TSWT_ASSERT_NXT(a_apply_done, state == S_APPLY, state == S_DONE, "apply not followed by done")
  `TSWT_ASSERT_NXT(a_done_load, cmd.load_out, out_valid && state == S_IDLE, "result load lost")

endmodule

// ----- rtl/core/tswt_dp.sv -----
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer datapath
// Counter, leap register, recorded time, slot stamps and result registers.
// ----------------------------------------------------------------------------
module tswt_dp import tswt_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_wr,
  input  logic [LEAP_W-1:0]  cfg_data,
  input  logic [OP_W-1:0]    operation,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [STAMP_W-1:0] sys_time,
  output logic [STAMP_W-1:0] tick_count,
  output logic [STAMP_W-1:0] last_time,
  output logic [MASK_W-1:0]  fired_mask,
  output logic               rejected
);

  logic [LEAP_W-1:0]  leap;
  logic [STAMP_W-1:0] counter, counter_next;
  logic [STAMP_W-1:0] stored_time;
  logic [STAMP_W-1:0] slot_stamp [SLOTS];
  logic [OP_W-1:0]    op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [STAMP_W-1:0] time_q;
  logic [STAMP_W-1:0] operand;
  logic [MASK_W-1:0]  fired_q;

  logic [STAMP_W:0]         sum;
  logic [STAMP_W-1:0]       leap_ext;
  logic [STAMP_W-1:0]       opnd;
  logic [SLOTS-1:0]         le;
  logic [SLOTS-1:0]         fired_all;
  logic [SLOTS+MASK_W-1:0]  fired_ext;
  logic                     is_tick;
  logic                     stamp_zero;

  assign leap_ext     = {{(STAMP_W-LEAP_W){1'b0}}, leap};
  assign sum          = {1'b0, counter} + {1'b0, leap_ext};
  assign counter_next = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
  assign is_tick      = (op_q == OP_TICK);
  assign stamp_zero   = (stamp_q == '0);
  assign opnd         = is_tick ? counter : operand;

  assign stat.skip = (is_tick && leap == '0) || (op_q == OP_BEFORE && stamp_zero) ||
                     (op_q == OP_NONE);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      le[i]        = (slot_stamp[i] <= opnd);
      fired_all[i] = is_tick && (slot_stamp[i] != '0) && le[i];
    end
  end

  assign fired_ext = {{MASK_W{1'b0}}, fired_all};

  always_ff @(posedge clk) begin
    if (rst) begin
      leap        <= LEAP_W'(1);
      counter     <= STAMP_W'(1);
      stored_time <= '0;
      for (int i = 0; i < SLOTS; i++) slot_stamp[i] <= '0;
    end else begin
      if (cfg_wr) leap <= cfg_data;
      if (cmd.calc && is_tick) begin
        counter     <= counter_next;
        stored_time <= time_q;
      end
      if (cmd.apply) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (is_tick) begin
            if (fired_all[i]) slot_stamp[i] <= '0;
          end else if ({{(32-SLOT_W){1'b0}}, slot_q} == 32'(i)) begin
            if (operand == '0) slot_stamp[i] <= '0;
            else if (slot_stamp[i] == '0 || !le[i]) slot_stamp[i] <= operand;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= operation;
      slot_q  <= slot;
      stamp_q <= stamp;
      time_q  <= sys_time;
      fired_q <= '0;
    end
    if (cmd.calc) begin
      if (op_q == OP_BEFORE && stamp_q > leap_ext) operand <= stamp_q - leap_ext;
      else operand <= stamp_q;
    end
    if (cmd.apply) fired_q <= fired_ext[MASK_W-1:0];
    if (cmd.load_out) begin
      tick_count <= counter;
      last_time  <= stored_time;
      fired_mask <= fired_q;
      rejected   <= (op_q == OP_BEFORE) && stamp_zero;
    end
  end

endmodule

// ----- rtl/core/tick_stamp_wakeup_timer_top.sv -----
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer
// 64-bit saturating tick counter with compare slots that fire on ticks.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    operation, slot, stamp, sys_time
//   out      out_valid / out_ready  tick_count, last_time, fired_mask, rejected
//   cfg      cfg_valid / cfg_ready  cfg_data (leap)
//
// An item steps through accept, counter or stamp update, slot compare/write
// and result load, set by the controller FSM; a rejected, ignored or
// zero-leap tick item skips the update and the slot compare/write.
// The result register lets a new item be accepted while the last one waits.
// Reset is synchronous; all slots come out disarmed, no clearing pass.
// A stalled output holds the FSM in its load state until the transfer.
// ----------------------------------------------------------------------------
module tick_stamp_wakeup_timer_top import tswt_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [STAMP_W-1:0] sys_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAMP_W-1:0] tick_count,
  output logic [STAMP_W-1:0] last_time,
  output logic [MASK_W-1:0]  fired_mask,
  output logic               rejected,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEAP_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tswt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tswt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .slot        (slot),
    .stamp       (stamp),
    .sys_time    (sys_time),
    .tick_count  (tick_count),
    .last_time   (last_time),
    .fired_mask  (fired_mask),
    .rejected    (rejected)
  );

endmodule

// ----- dv/tswt_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer scoreboard
// Tracks counter, recorded time and slot stamps for every accepted item and
// checks each output transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
package tswt_tb_pkg;
  import tswt_pkg::*;

  localparam int TIMER_SLOTS = 8;

  typedef struct packed {
    logic [STAMP_W-1:0] tick_count;
    logic [STAMP_W-1:0] last_time;
    logic [MASK_W-1:0]  fired_mask;
    logic               rejected;
  } timer_result_t;

  class timer_scoreboard;
    logic [LEAP_W-1:0]  leap;
    logic [STAMP_W-1:0] count;
    logic [STAMP_W-1:0] last_tm;
    logic [STAMP_W-1:0] stamps[TIMER_SLOTS];
    timer_result_t      due_results[$];
    int                 errors;
    int                 checked;
    int                 ticks;
    int                 wakeups;
    int                 rejects;

    function new();
      leap    = 1;
      count   = 1;
      last_tm = '0;
      foreach (stamps[i]) stamps[i] = '0;
      errors  = 0;
      checked = 0;
      ticks   = 0;
      wakeups = 0;
      rejects = 0;
    endfunction

    function void set_leap(logic [LEAP_W-1:0] v);
      leap = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void arm(logic [SLOT_W-1:0] sl, logic [STAMP_W-1:0] st);
      if (st == '0) stamps[sl] = '0;
      else if (stamps[sl] == '0 || st < stamps[sl]) stamps[sl] = st;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sl,
                            logic [STAMP_W-1:0] st, logic [STAMP_W-1:0] tm);
      timer_result_t      r;
      logic [STAMP_W:0]   sum;
      logic [STAMP_W-1:0] st_adj;
      r = '0;
      case (op)
        OP_TICK: begin
          if (leap != '0) begin
            sum = {1'b0, count} + {{(STAMP_W+1-LEAP_W){1'b0}}, leap};
            count = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
            last_tm = tm;
            ticks++;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
              if (stamps[i] != '0 && stamps[i] <= count) begin
                stamps[i] = '0;
                r.fired_mask[i] = 1'b1;
                wakeups++;
              end
            end
          end
        end
        OP_AFTER: arm(sl, st);
        OP_BEFORE: begin
          if (st == '0) begin
            r.rejected = 1'b1;
            rejects++;
          end else begin
            st_adj = (st > {32'd0, leap}) ? st - {32'd0, leap} : st;
            arm(sl, st_adj);
          end
        end
        default: ;
      endcase
      r.tick_count = count;
      r.last_time  = last_tm;
      due_results.insert(due_results.size(), r);
    endfunction

    function void field_ok(string name, logic [STAMP_W-1:0] exp_v,
                           logic [STAMP_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [STAMP_W-1:0] cnt, logic [STAMP_W-1:0] tm,
                               logic [MASK_W-1:0] mask, logic rej);
      timer_result_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual count %h mask %h",
                 $time, cnt, mask);
        errors++;
      end else begin
        e = due_results.pop_front();
        checked++;
        field_ok("tick_count", e.tick_count, cnt);
        field_ok("last_time", e.last_time, tm);
        field_ok("fired_mask", {56'd0, e.fired_mask}, {56'd0, mask});
        field_ok("rejected", {63'd0, e.rejected}, {63'd0, rej});
      end
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick stamp wakeup timer testbench
// Directed arm/tick sequences at reset leap, then random phases over several
// leap settings (zero and full scale included) with random idling on both
// channels (one phase calm); every output transfer is checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top import tswt_pkg::*, tswt_tb_pkg::*;;

  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 325;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    operation;
  logic [SLOT_W-1:0]  slot;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] sys_time;
  logic               out_valid;
  logic               out_ready;
  logic [STAMP_W-1:0] tick_count;
  logic [STAMP_W-1:0] last_time;
  logic [MASK_W-1:0]  fired_mask;
  logic               rejected;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEAP_W-1:0]  cfg_data;

  timer_scoreboard sb = new();
  bit              calm;
  logic [LEAP_W-1:0] leap_plan[PHASES];

  tick_stamp_wakeup_timer_top #(.SLOTS(TIMER_SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .slot(slot), .stamp(stamp), .sys_time(sys_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .tick_count(tick_count), .last_time(last_time),
    .fired_mask(fired_mask), .rejected(rejected),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(tick_count, last_time, fired_mask, rejected);
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sl,
                           input logic [STAMP_W-1:0] st, input logic [STAMP_W-1:0] tm);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    slot        <= sl;
    stamp       <= st;
    sys_time    <= tm;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, sl, st, tm);
  endtask

  task automatic write_leap(input logic [LEAP_W-1:0] v);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_leap(v);
  endtask

  function automatic logic [STAMP_W-1:0] pick_stamp();
    logic [STAMP_W-1:0] step;
    logic [STAMP_W-1:0] v;
    int unsigned        r;
    step = (sb.leap == '0) ? 64'd1 : {32'd0, sb.leap};
    r = $urandom_range(0, 99);
    if (r < 8) v = '0;
    else if (r < 14) v = '1;
    else if (r < 30) v = {$urandom, $urandom};
    else if (r < 45) v = step + 64'($urandom_range(0, 2)) - 64'd1;
    else v = sb.count + step * 64'($urandom_range(0, 5)) + 64'($urandom_range(0, 2)) - 64'd1;
    return v;
  endfunction

  function automatic logic [STAMP_W-1:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_TICK;
    if (r < 65) return OP_AFTER;
    if (r < 94) return OP_BEFORE;
    return OP_NONE;
  endfunction

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    operation   <= OP_TICK;
    slot        <= '0;
    stamp       <= '0;
    sys_time    <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    calm        = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset leap of 1: arm, tighten, disarm, reject, then ticks that fire
    send_item(OP_TICK,   3'd0, '0,      '1);
    send_item(OP_AFTER,  3'd0, 64'd3,   '0);
    send_item(OP_AFTER,  3'd0, 64'd5,   '0);
    send_item(OP_AFTER,  3'd1, 64'd10,  '0);
    send_item(OP_AFTER,  3'd1, 64'd4,   '0);
    send_item(OP_AFTER,  3'd2, '0,      '0);
    send_item(OP_AFTER,  3'd3, 64'd6,   '0);
    send_item(OP_AFTER,  3'd3, '0,      '0);
    send_item(OP_BEFORE, 3'd4, '0,      '1);
    send_item(OP_BEFORE, 3'd5, 64'd1,   '0);
    send_item(OP_BEFORE, 3'd6, 64'd8,   '0);
    send_item(OP_BEFORE, 3'd7, '1,      '0);
    send_item(OP_AFTER,  3'd7, '1,      '1);
    send_item(OP_NONE,   3'd5, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(OP_TICK,   3'd0, '0,      '0);
    send_item(OP_TICK,   3'd7, '1,      64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_TICK,   3'd0, '0,      64'h5555_5555_5555_5555);
    send_item(OP_TICK,   3'd2, 64'd7,   64'h0123_4567_89AB_CDEF);
    send_item(OP_TICK,   3'd6, 64'd9,   '1);
    in_valid <= 1'b0;

    leap_plan[0] = 32'hFFFF_FFFF;
    leap_plan[1] = 32'd0;
    leap_plan[2] = 32'd1;
    leap_plan[3] = 32'($urandom_range(2, 64));
    leap_plan[4] = 32'h8000_0000;
    leap_plan[5] = 32'($urandom_range(1, 32'hFFFF_FFFF));

    for (int p = 0; p < PHASES; p++) begin
      write_leap(leap_plan[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(pick_op(), 3'($urandom_range(0, TIMER_SLOTS - 1)), pick_stamp(),
                  pick_time());
      in_valid <= 1'b0;
    end
    calm = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d results over %0d leap settings: %0d effective ticks,",
             sb.checked, PHASES + 1, sb.ticks);
    $display("%0d slot wakeups and %0d rejected arm_before requests.",
             sb.wakeups, sb.rejects);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- tick_stamp_wakeup_timer_top.f -----
+incdir+rtl/core
rtl/core/tswt_pkg.sv
rtl/core/tswt_ctrl.sv
rtl/core/tswt_dp.sv
rtl/core/tick_stamp_wakeup_timer_top.sv
dv/tswt_tb_pkg.sv
dv/tb_top.sv
